// ----- hw/rtl/dnc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_pkg: shared constants and functions for the double normal curve evaluator
// Holds the register map, the fixed-point widths and the elaboration-time
// functions that build the 2^(-fraction) mantissa table.
// ----------------------------------------------------------------------------
package dnc_pkg;

  // Register map of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_POSITION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPREAD_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPREAD_RIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT      = 2'd3;

  // Field and register widths.
  localparam int DATA_W = 16;

  // Reset values of the registers.
  localparam logic [DATA_W-1:0] PEAK_POSITION_RST = 16'd0;
  localparam logic [DATA_W-1:0] INV_SPREAD_RST    = 16'd4096;
  localparam logic [DATA_W-1:0] PEAK_HEIGHT_RST   = 16'd16384;

  // Fixed-point layout of the exponent path.
  localparam int ZQ_W      = 24;        // |x-mu|*inv >> 8, Q.12
  localparam int ZQ_USED_W = 15;        // zq below the far-tail limit fits here
  localparam logic [ZQ_W-1:0] ZQ_LIMIT = 24'd24576;  // z of 6.0 in Q.12
  localparam int E_W       = 2 * ZQ_USED_W;          // z^2, Q.24
  localparam int FRAC_W    = 24;        // fraction bits of z^2
  localparam int EXP_INT_W = E_W - FRAC_W;           // integer bits of z^2
  localparam int MANT_W    = 33;        // 2^(-g) in Q0.32, 1.0 included
  localparam int ROOT_STEPS = 24;

  typedef logic [ROOT_STEPS:1][31:0] root_tab_t;

  // Bitwise integer square root, floor of sqrt(v).
  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Root constants c_j = 2^(-2^-j) in Q0.32, each one the root of the last.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] c;
    c = int_sqrt(64'd1 << 63);
    t[1] = c[31:0];
    for (int j = 2; j <= ROOT_STEPS; j++) begin
      c = int_sqrt({c[31:0], 32'd0});
      t[j] = c[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

  // 2^(-g) for a Q.24 fraction g, as a truncating product of root constants.
  function automatic logic [MANT_W-1:0] pow2_neg_frac(input logic [FRAC_W-1:0] g);
    logic [63:0] acc;
    acc = 64'd1 << 32;
    for (int j = 1; j <= ROOT_STEPS; j++) begin
      if (g[ROOT_STEPS-j]) acc = (acc * {32'd0, ROOTS[j]}) >> 32;
    end
    return acc[MANT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/double_normal_curve_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_normal_curve_eval: pipelined double normal selectivity curve
// Computes alpha * 2^(-z^2) with z = |x - mu| * inverse sigma, the left or
// right inverse sigma chosen by the side of the peak, and flags bad settings.
// ----------------------------------------------------------------------------
// The block takes one position per clock while no result is held at the
// output and offers each selectivity, in order, through a seven-stage
// pipeline: side select, spread multiply, square, exponent split, fraction
// table read, height multiply, and the final shift into the output register.
// The three multipliers and the mantissa table each own a stage. A stall
// on a held result freezes the whole pipeline and is passed straight back to
// in_stall; no transaction is lost or repeated. Configuration registers may
// only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module double_normal_curve_eval
  import dnc_pkg::*;
#(
  parameter int FRAC_TABLE_DEPTH = 256,
  parameter int EXP_CUTOFF       = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_position,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_selectivity,
  output logic                 out_setting_error
);

  localparam int Q_W     = $clog2(FRAC_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(FRAC_TABLE_DEPTH + 1);
  localparam int SCL_W   = FRAC_W + DEPTH_W;
  localparam int PROD_W  = DATA_W + MANT_W;
  localparam int HI_W    = PROD_W - 32;
  localparam int STAGES  = 6;   // stages ahead of the output register

  // Configuration registers.
  logic [DATA_W-1:0] peak_position_r;
  logic [DATA_W-1:0] inv_spread_left_r;
  logic [DATA_W-1:0] inv_spread_right_r;
  logic [DATA_W-1:0] peak_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_position_r    <= PEAK_POSITION_RST;
      inv_spread_left_r  <= INV_SPREAD_RST;
      inv_spread_right_r <= INV_SPREAD_RST;
      peak_height_r      <= PEAK_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PEAK_POSITION:    peak_position_r    <= cfg_wdata;
        REG_INV_SPREAD_LEFT:  inv_spread_left_r  <= cfg_wdata;
        REG_INV_SPREAD_RIGHT: inv_spread_right_r <= cfg_wdata;
        REG_PEAK_HEIGHT:      peak_height_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is held at the output.
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Valid bits that travel with the data.
  logic [STAGES:1] vld_r;
  logic            out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[STAGES-1:1], in_valid};
      out_valid_r <= vld_r[STAGES];
    end
  end

  // Mantissa table 2^(-g), one entry per quantized fraction step.
  logic [MANT_W-1:0] frac_tab [FRAC_TABLE_DEPTH];

  for (genvar k = 0; k < FRAC_TABLE_DEPTH; k++) begin : g_frac_tab
    localparam logic [FRAC_W-1:0] G_STEP =
      FRAC_W'((64'(k) << FRAC_W) / FRAC_TABLE_DEPTH);
    assign frac_tab[k] = pow2_neg_frac(G_STEP);
  end

  // Stage 1: distance from the peak and choice of the spread.
  logic [DATA_W-1:0] dist_r, inv_r;
  logic              below_peak;
  assign below_peak = in_position < peak_position_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      dist_r <= below_peak ? peak_position_r - in_position : in_position - peak_position_r;
      inv_r  <= below_peak ? inv_spread_left_r : inv_spread_right_r;
    end
  end

  // Stage 2: scaled distance z in Q.12 and the far-tail check.
  logic [2*DATA_W-1:0] zprod;
  logic [ZQ_W-1:0]     zq;
  logic [ZQ_USED_W-1:0] zq_r;
  logic                 far2_r;
  assign zprod = dist_r * inv_r;
  assign zq    = zprod[2*DATA_W-1:8];

  always_ff @(posedge clk) begin
    if (advance) begin
      zq_r   <= zq[ZQ_USED_W-1:0];
      far2_r <= zq >= ZQ_LIMIT;
    end
  end

  // Stage 3: square of z in Q.24.
  logic [E_W-1:0] esq_r;
  logic           far3_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      esq_r  <= zq_r * zq_r;
      far3_r <= far2_r;
    end
  end

  // Stage 4: split into the shift count and the quantized fraction.
  logic [EXP_INT_W-1:0] exp_int;
  logic [SCL_W-1:0]     frac_scaled;
  logic [EXP_INT_W-1:0] exp_int4_r;
  logic [Q_W-1:0]       q_r;
  logic                 kill4_r;
  assign exp_int     = esq_r[E_W-1:FRAC_W];
  assign frac_scaled = SCL_W'(esq_r[FRAC_W-1:0]) * SCL_W'(FRAC_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (advance) begin
      exp_int4_r <= exp_int;
      q_r        <= frac_scaled[FRAC_W +: Q_W];
      kill4_r    <= far3_r || (exp_int >= EXP_INT_W'(EXP_CUTOFF));
    end
  end

  // Stage 5: mantissa table read.
  logic [MANT_W-1:0]    mant_r;
  logic [EXP_INT_W-1:0] exp_int5_r;
  logic                 kill5_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      mant_r     <= frac_tab[q_r];
      exp_int5_r <= exp_int4_r;
      kill5_r    <= kill4_r;
    end
  end

  // Stage 6: scale by the peak height.
  logic [PROD_W-1:0]    prod_r;
  logic [EXP_INT_W-1:0] exp_int6_r;
  logic                 kill6_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r     <= PROD_W'(peak_height_r) * PROD_W'(mant_r);
      exp_int6_r <= exp_int5_r;
      kill6_r    <= kill5_r;
    end
  end

  // Output stage: integer shift, far-tail zeroing, saturation and the settings flag.
  logic [HI_W-1:0]   shifted;
  logic [DATA_W-1:0] sel_val;
  logic              set_err;
  logic [DATA_W-1:0] out_selectivity_r;
  logic              out_setting_error_r;

  assign shifted = prod_r[PROD_W-1:32] >> exp_int6_r;
  assign set_err = (peak_height_r == '0) || (inv_spread_left_r == '0) ||
                   (inv_spread_right_r == '0);

  always_comb begin
    if (kill6_r) begin
      sel_val = '0;
    end else if (shifted > HI_W'({DATA_W{1'b1}})) begin
      sel_val = '1;
    end else begin
      sel_val = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_selectivity_r   <= sel_val;
      out_setting_error_r <= set_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_selectivity   = out_selectivity_r;
  assign out_setting_error = out_setting_error_r;

endmodule

// ----- hw/rtl/dnc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnc_checker: port-level checks for the double normal curve evaluator
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module dnc_checker
  import dnc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_selectivity,
  input logic              out_setting_error
);

  // The input side is held back only by a result waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");

  // A held result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_selectivity) && $stable(out_setting_error)))
    else $error("held result changed");

endmodule

bind double_normal_curve_eval dnc_checker u_dnc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_selectivity   (out_selectivity),
  .out_setting_error (out_setting_error)
);
